FILE: rtl/core/memory_map_with_oam_dma_unit_assert.svh
// Assertion helpers for the memory map with sprite-table copy.
`ifndef MEMORY_MAP_WITH_OAM_DMA_UNIT_ASSERT_SVH
`define MEMORY_MAP_WITH_OAM_DMA_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MMDMA_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MMDMA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/core/mmdma_pkg.sv
package mmdma_pkg;

	localparam int ADDR_W = 16;
	localparam int DATA_W = 8;
	localparam int KIND_W = 2;
	localparam int MEM_DEPTH = 65536;

	localparam logic [KIND_W-1:0] KIND_READ = 2'd0;
	localparam logic [KIND_W-1:0] KIND_CPU  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_RAW  = 2'd2;

	localparam logic [ADDR_W-1:0] ADDR_DMA      = 16'hFF46;
	localparam logic [ADDR_W-1:0] ADDR_SCANLINE = 16'hFF44;
	localparam logic [ADDR_W-1:0] ADDR_TIMA     = 16'hFF05;
	localparam logic [ADDR_W-1:0] ADDR_DIV      = 16'hFF04;
	localparam logic [ADDR_W-1:0] OAM_BASE      = 16'hFE00;
	localparam logic [ADDR_W-1:0] ECHO_LO       = 16'hE000;
	localparam logic [ADDR_W-1:0] ECHO_HI       = 16'hFE00;
	localparam logic [ADDR_W-1:0] ECHO_OFFSET   = 16'h2000;
	localparam logic [ADDR_W-1:0] ROM_END       = 16'h8000;
	localparam logic [ADDR_W-1:0] ADDR_MAX      = 16'hFFFF;

	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] addr;
		logic [DATA_W-1:0] data;
	} ram_wr_t;

	typedef struct packed {
		logic [ADDR_W-1:0] addr;
		logic              is_scan;
		logic              is_div;
	} rmap_t;

	typedef struct packed {
		ram_wr_t wr;
		logic    timer_rs;
		logic    div_rs;
		logic    disp_rs;
		logic    dma;
	} cwr_t;

	typedef struct packed {
		logic [DATA_W-1:0] read_data;
		logic              timer_restart;
		logic              divider_restart;
		logic              display_restart;
		logic              dma_done;
	} res_t;

	function automatic rmap_t read_map(input logic [ADDR_W-1:0] a);
		rmap_t r;
		r = '0;
		r.addr = a;
		if (a >= ECHO_LO && a < ECHO_HI) begin
			r.addr = a - ECHO_OFFSET;
		end else if (a == ADDR_SCANLINE) begin
			r.is_scan = 1'b1;
		end else if (a == ADDR_DIV) begin
			r.is_div = 1'b1;
		end
		return r;
	endfunction

	function automatic cwr_t cpu_write(input logic [ADDR_W-1:0] a, input logic [DATA_W-1:0] d);
		cwr_t c;
		c = '0;
		if (a >= ROM_END) begin
			if (a == ADDR_DMA) begin
				c.dma = 1'b1;
			end else if (a >= ECHO_LO && a < ECHO_HI) begin
				c.wr.we = 1'b1;
				c.wr.addr = a - ECHO_OFFSET;
				c.wr.data = d;
			end else if (a == ADDR_SCANLINE) begin
				c.disp_rs = 1'b1;
			end else if (a == ADDR_TIMA) begin
				c.wr.we = 1'b1;
				c.wr.addr = a;
				c.timer_rs = 1'b1;
			end else if (a == ADDR_DIV) begin
				c.wr.we = 1'b1;
				c.wr.addr = a;
				c.div_rs = 1'b1;
			end else begin
				c.wr.we = 1'b1;
				c.wr.addr = a;
				c.wr.data = d;
			end
		end
		return c;
	endfunction

endpackage

FILE: rtl/core/mmdma_if.sv
interface mmdma_req_if;
	import mmdma_pkg::*;

	logic              valid;
	logic              ready;
	logic [KIND_W-1:0] kind;
	logic [ADDR_W-1:0] address;
	logic [DATA_W-1:0] data;
	logic [DATA_W-1:0] scanline_now;
	logic [DATA_W-1:0] divider_now;

	modport source (output valid, kind, address, data, scanline_now, divider_now, input ready);
	modport sink (input valid, kind, address, data, scanline_now, divider_now, output ready);
endinterface

interface mmdma_rsp_if;
	import mmdma_pkg::*;

	logic              valid;
	logic              ready;
	logic [DATA_W-1:0] read_data;
	logic              timer_restart;
	logic              divider_restart;
	logic              display_restart;
	logic              dma_done;

	modport source (output valid, read_data, timer_restart, divider_restart, display_restart,
		dma_done, input ready);
	modport sink (input valid, read_data, timer_restart, divider_restart, display_restart,
		dma_done, output ready);
endinterface

FILE: rtl/core/mmdma_ram.sv
module mmdma_ram (
	input  logic                        clk,
	input  mmdma_pkg::ram_wr_t          wr,
	input  logic [mmdma_pkg::ADDR_W-1:0] raddr,
	output logic [mmdma_pkg::DATA_W-1:0] rdata
);
	import mmdma_pkg::*;

	logic [DATA_W-1:0] mem [MEM_DEPTH];
	logic [DATA_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (wr.we) begin
			mem[wr.addr] <= wr.data;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;
endmodule

FILE: rtl/core/memory_map_with_oam_dma_unit.sv
// Channel | Modport | Word carries
// req     | sink    | kind, address, data, scanline_now, divider_now
// rsp     | source  | read_data, timer_restart, divider_restart, display_restart, dma_done
//
// A write or an unused kind ends on acceptance, a read goes via ST_READ, and a sprite-table copy
// alternates ST_DMA_RD and ST_DMA_WR for DMA_LENGTH bytes, as the single byte RAM reads registered.
// After reset a clearing pass writes zero to all 65536 bytes, one per cycle, before the
// first word is accepted.
// The result sits in an output register; a new word is accepted while it waits, and the
// next result is parked until the output register frees up.
module memory_map_with_oam_dma_unit #(
	parameter int DMA_LENGTH = 160
) (
	input logic        clk,
	input logic        arst_n,
	mmdma_req_if.sink   req,
	mmdma_rsp_if.source rsp
);
	import mmdma_pkg::*;

	localparam int CntW = (DMA_LENGTH > 1) ? $clog2(DMA_LENGTH) : 1;
	localparam logic [CntW-1:0] CntLast = CntW'(DMA_LENGTH - 1);

	typedef enum logic [5:0] {
		ST_CLEAR  = 6'b000001,
		ST_IDLE   = 6'b000010,
		ST_READ   = 6'b000100,
		ST_DMA_RD = 6'b001000,
		ST_DMA_WR = 6'b010000,
		ST_HOLD   = 6'b100000
	} state_t;

	state_t            state_q, state_d;
	logic [ADDR_W-1:0] clr_q;
	logic [CntW-1:0]   cnt_q;
	logic [DATA_W-1:0] page_q, scan_q, div_q;
	logic              sp_q;
	logic [DATA_W-1:0] spv_q;
	logic              out_valid_q;
	res_t              out_q, res_q;

	logic              acc, out_free, fin;
	res_t              fin_res;
	ram_wr_t           ram_wr;
	logic [DATA_W-1:0] ram_rdata;
	logic [ADDR_W-1:0] src_addr;
	rmap_t             rm;
	cwr_t              cw;
	logic [DATA_W-1:0] live_scan, live_div, rd_byte;
	logic [3:0]        out_flags;

	assign req.ready = (state_q == ST_IDLE);
	assign acc = req.valid && req.ready;
	assign out_free = !out_valid_q || rsp.ready;

	assign src_addr = ADDR_W'({page_q, 8'h00}) + ADDR_W'(cnt_q);
	assign rm = read_map((state_q == ST_DMA_RD) ? src_addr : req.address);
	assign live_scan = (state_q == ST_DMA_RD) ? scan_q : req.scanline_now;
	assign live_div = (state_q == ST_DMA_RD) ? div_q : req.divider_now;
	assign cw = cpu_write(req.address, req.data);
	assign rd_byte = sp_q ? spv_q : ram_rdata;

	mmdma_ram u_ram (
		.clk   (clk),
		.wr    (ram_wr),
		.raddr (rm.addr),
		.rdata (ram_rdata)
	);

	always_comb begin
		state_d = state_q;
		ram_wr = '0;
		fin = 1'b0;
		fin_res = '0;
		case (state_q)
			ST_CLEAR: begin
				ram_wr.we = 1'b1;
				ram_wr.addr = clr_q;
				if (clr_q == ADDR_MAX) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (acc) begin
					case (req.kind)
						KIND_READ: state_d = ST_READ;
						KIND_CPU: begin
							if (cw.dma) begin
								state_d = ST_DMA_RD;
							end else begin
								ram_wr = cw.wr;
								fin = 1'b1;
								fin_res.timer_restart = cw.timer_rs;
								fin_res.divider_restart = cw.div_rs;
								fin_res.display_restart = cw.disp_rs;
							end
						end
						KIND_RAW: begin
							ram_wr.we = 1'b1;
							ram_wr.addr = req.address;
							ram_wr.data = req.data;
							fin = 1'b1;
						end
						default: fin = 1'b1;
					endcase
				end
			end
			ST_READ: begin
				fin = 1'b1;
				fin_res.read_data = rd_byte;
			end
			ST_DMA_RD: state_d = ST_DMA_WR;
			ST_DMA_WR: begin
				ram_wr.we = 1'b1;
				ram_wr.addr = OAM_BASE + ADDR_W'(cnt_q);
				ram_wr.data = rd_byte;
				if (cnt_q == CntLast) begin
					fin = 1'b1;
					fin_res.dma_done = 1'b1;
				end else begin
					state_d = ST_DMA_RD;
				end
			end
			ST_HOLD: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
		if (fin) begin
			state_d = out_free ? ST_IDLE : ST_HOLD;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q <= '0;
			cnt_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + ADDR_W'(1);
			end
			if (acc) begin
				cnt_q <= '0;
			end else if (state_q == ST_DMA_WR) begin
				cnt_q <= cnt_q + CntW'(1);
			end
			if ((fin || state_q == ST_HOLD) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fin && out_free) begin
			out_q <= fin_res;
		end else if (state_q == ST_HOLD && out_free) begin
			out_q <= res_q;
		end
		if (fin && !out_free) begin
			res_q <= fin_res;
		end
		if (acc) begin
			page_q <= req.data;
			scan_q <= req.scanline_now;
			div_q <= req.divider_now;
		end
		sp_q <= rm.is_scan || rm.is_div;
		spv_q <= rm.is_scan ? live_scan : live_div;
	end

	assign rsp.valid = out_valid_q;
	assign rsp.read_data = out_q.read_data;
	assign rsp.timer_restart = out_q.timer_restart;
	assign rsp.divider_restart = out_q.divider_restart;
	assign rsp.display_restart = out_q.display_restart;
	assign rsp.dma_done = out_q.dma_done;

	assign out_flags = {out_q.timer_restart, out_q.divider_restart, out_q.display_restart,
		out_q.dma_done};

`include "memory_map_with_oam_dma_unit_assert.svh"

	`MMDMA_ASSERT_NOW(a_clear_quiet, clk, arst_n, state_q == ST_CLEAR, !out_valid_q && !req.ready, "word moved during the clearing pass")
	`MMDMA_ASSERT_NEXT(a_dma_start, clk, arst_n, acc && req.kind == KIND_CPU && req.address == ADDR_DMA, state_q == ST_DMA_RD, "copy trigger did not start the copy")
	`MMDMA_ASSERT_NOW(a_oam_dest, clk, arst_n, state_q == ST_DMA_WR, ram_wr.we && ram_wr.addr[15:8] == OAM_BASE[15:8], "copy write outside the sprite table")
	`MMDMA_ASSERT_NOW(a_one_flag, clk, arst_n, out_valid_q, $onehot0(out_flags), "more than one flag in a result word")

endmodule
